>>> src/assert_macros.svh
// Assertion macros for RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, clocked on clock, off in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bavg_pkg.sv
// Shared types and constants of the block average downsampler
`default_nettype none

package bavg_pkg;

   // Register field widths
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 12;
   localparam int BLOCK_REG_W  = 5;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Height limit and row counter widths
   localparam int HGT_LIMIT = 2048;
   localparam int HGT_W     = 12;
   localparam int ROW_W     = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_WIDTH  = 2'd0,
      CSR_IN_HEIGHT = 2'd1,
      CSR_BLOCK_W   = 2'd2,
      CSR_BLOCK_H   = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SETUP_WAIT,
      ST_RMW,
      ST_DIV
   } state_type;

endpackage

`default_nettype wire

>>> src/bavg_div.sv
// Multi-lane restoring divider, one quotient bit per lane each cycle
`default_nettype none

module bavg_div #(
   parameter int LANES = 3,
   parameter int N_W   = 24,
   parameter int D_W   = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [LANES-1:0][N_W-1:0]  dividend,
   input  logic [LANES-1:0][D_W-1:0]  divisor,
   output logic                       busy,
   output logic [LANES-1:0][N_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic                      busy_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [LANES-1:0][N_W-1:0] quo_ff;
   logic [LANES-1:0][N_W-1:0] quo_in;
   logic [LANES-1:0][D_W-1:0] rem_ff;
   logic [LANES-1:0][D_W-1:0] rem_in;
   logic [LANES-1:0][D_W-1:0] dvs_ff;

   // One restoring step per lane: shift in the next dividend bit, try subtract
   always_comb begin
      logic [D_W:0] trial;
      logic [D_W:0] diff;
      logic         fits;
      trial = '0;
      diff  = '0;
      fits  = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         trial     = {rem_ff[i], quo_ff[i][N_W-1]};
         diff      = trial - {1'b0, dvs_ff[i]};
         fits      = (trial >= {1'b0, dvs_ff[i]});
         rem_in[i] = fits ? diff[D_W-1:0] : trial[D_W-1:0];
         quo_in[i] = {quo_ff[i][N_W-2:0], fits};
      end
   end

   // Step counter and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(N_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Load operands on start, advance while busy, hold the quotient after
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> src/block_average_downsampler.sv
// Top level of the block average downsampler: tile accumulation and averaging
//
//   channel | direction | word                         | side info
//   --------+-----------+------------------------------+--------------------------
//   req_    | in        | red, green, blue pixel       | none
//   rsp_    | out       | averaged red, green, blue    | tlast on last tile of row
//   csr_    | in        | register index and value     | none
//
// A pixel outside a whole tile is taken in ST_IDLE alone; for a pixel added to a tile the
// accumulator memory is read on accept, then the sum is added and written back in ST_RMW.
// The pixel that closes a tile then waits in ST_DIV on the bit-serial divider.
// After reset and after each register write a setup pass derives tiles across, rows used
// and tile area; req_tready is low meanwhile.
// A stalled result sits in the output register; the next tile average waits behind it.
`default_nettype none

module block_average_downsampler #(
   parameter int MAX_WIDTH    = 2048,
   parameter int MAX_TILE     = 16,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // Pixel in: red, green, blue from the lowest bit up, zero padded to bytes
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          req_tdata,
   // Average out: red, green, blue from the lowest bit up, zero padded to bytes
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]          rsp_tdata,
   output logic                                         rsp_tlast,
   // Register writes
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [bavg_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [bavg_pkg::CSR_DATA_W-1:0]              csr_data
);

   `include "assert_macros.svh"

   localparam int DATA_W  = ((3*CHANNEL_BITS+7)/8)*8;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int W_W     = $clog2(MAX_WIDTH + 1);
   localparam int TILE_W  = $clog2(MAX_TILE);
   localparam int BW_W    = $clog2(MAX_TILE + 1);
   localparam int AREA_W  = $clog2(MAX_TILE*MAX_TILE + 1);
   localparam int SUM_W   = CHANNEL_BITS + $clog2(MAX_TILE*MAX_TILE);
   localparam int HGT_W   = bavg_pkg::HGT_W;
   localparam int ROW_W   = bavg_pkg::ROW_W;
   localparam int CFG_N_W = (W_W > HGT_W) ? W_W : HGT_W;

   // Configuration registers
   logic [bavg_pkg::WIDTH_REG_W-1:0]  in_width_ff;
   logic [bavg_pkg::HEIGHT_REG_W-1:0] in_height_ff;
   logic [bavg_pkg::BLOCK_REG_W-1:0]  block_w_ff;
   logic [bavg_pkg::BLOCK_REG_W-1:0]  block_h_ff;
   logic                              dirty_ff;
   logic                              dirty_in;
   logic                              csr_wr;

   // Derived geometry
   logic [W_W-1:0]    w;
   logic [HGT_W-1:0]  h;
   logic [BW_W-1:0]   bw;
   logic [BW_W-1:0]   bh;
   logic [W_W-1:0]    tiles_across_ff;
   logic [HGT_W-1:0]  rows_used_ff;
   logic [AREA_W-1:0] area_ff;
   logic [CFG_N_W+BW_W-1:0] rows_full;
   logic [2*BW_W-1:0]       area_full;

   // Position counters
   logic [COL_W-1:0]  column_pos_ff,  column_pos_in;
   logic [TILE_W-1:0] tile_col_pos_ff, tile_col_pos_in;
   logic [COL_W-1:0]  tile_index_ff,  tile_index_in;
   logic [ROW_W-1:0]  row_pos_ff,     row_pos_in;
   logic [TILE_W-1:0] tile_row_pos_ff, tile_row_pos_in;
   logic [W_W-1:0]    col_inc;
   logic [BW_W-1:0]   tcol_inc;
   logic [BW_W-1:0]   trow_inc;
   logic [HGT_W-1:0]  row_inc;
   logic [W_W-1:0]    tidx_full;
   logic              tcol_wrap;

   // Item decode and latched item
   logic                    accept;
   logic                    active_now;
   logic                    first_now;
   logic                    last_now;
   logic                    row_end_now;
   logic [CHANNEL_BITS-1:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic [COL_W-1:0]        addr_ff;
   logic                    first_ff;
   logic                    last_ff;
   logic                    row_end_ff;

   // Accumulator memory
   logic [3*SUM_W-1:0] acc_mem [MAX_WIDTH];
   logic [3*SUM_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]   sum_r, sum_g, sum_b;

   // Control
   bavg_pkg::state_type state_ff, state_in;
   logic mem_we;
   logic div_start;
   logic cfg_start;
   logic setup_load;
   logic out_load;

   // Dividers
   logic                             pix_div_busy;
   logic [2:0][SUM_W-1:0]            pix_quo;
   logic                             cfg_div_busy;
   logic [1:0][CFG_N_W-1:0]          cfg_quo;

   // Output register
   logic                    rsp_valid_ff;
   logic [CHANNEL_BITS-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic                    rsp_last_ff;

   // Take register writes at any time; each one forces a new setup pass
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign dirty_in  = csr_wr ? 1'b1 : (cfg_start ? 1'b0 : dirty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= bavg_pkg::WIDTH_REG_W'(2048);
         in_height_ff <= bavg_pkg::HEIGHT_REG_W'(2048);
         block_w_ff   <= bavg_pkg::BLOCK_REG_W'(2);
         block_h_ff   <= bavg_pkg::BLOCK_REG_W'(2);
         dirty_ff     <= 1'b1;
      end else begin
         dirty_ff <= dirty_in;
         if (csr_wr) begin
            case (bavg_pkg::csr_reg_type'(csr_index))
               bavg_pkg::CSR_IN_WIDTH:  in_width_ff  <= csr_data;
               bavg_pkg::CSR_IN_HEIGHT: in_height_ff <= csr_data;
               bavg_pkg::CSR_BLOCK_W:   block_w_ff   <= csr_data[bavg_pkg::BLOCK_REG_W-1:0];
               bavg_pkg::CSR_BLOCK_H:   block_h_ff   <= csr_data[bavg_pkg::BLOCK_REG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Clamp the registers into their legal ranges
   always_comb begin
      if (in_width_ff == '0) begin
         w = W_W'(1);
      end else if (32'(in_width_ff) > MAX_WIDTH) begin
         w = W_W'(MAX_WIDTH);
      end else begin
         w = W_W'(in_width_ff);
      end
      if (in_height_ff == '0) begin
         h = HGT_W'(1);
      end else if (32'(in_height_ff) > bavg_pkg::HGT_LIMIT) begin
         h = HGT_W'(bavg_pkg::HGT_LIMIT);
      end else begin
         h = HGT_W'(in_height_ff);
      end
      if (block_w_ff == '0) begin
         bw = BW_W'(1);
      end else if (32'(block_w_ff) > MAX_TILE) begin
         bw = BW_W'(MAX_TILE);
      end else begin
         bw = BW_W'(block_w_ff);
      end
      if (block_h_ff == '0) begin
         bh = BW_W'(1);
      end else if (32'(block_h_ff) > MAX_TILE) begin
         bh = BW_W'(MAX_TILE);
      end else begin
         bh = BW_W'(block_h_ff);
      end
   end

   // Setup pass: tiles across = w / bw, rows used = (h / bh) * bh
   bavg_div #(
      .LANES (2),
      .N_W   (CFG_N_W),
      .D_W   (BW_W)
   ) u_cfg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cfg_start),
      .dividend ({CFG_N_W'(h), CFG_N_W'(w)}),
      .divisor  ({bh, bw}),
      .busy     (cfg_div_busy),
      .quotient (cfg_quo)
   );

   assign rows_full = (CFG_N_W+BW_W)'(cfg_quo[1]) * (CFG_N_W+BW_W)'(bh);
   assign area_full = (2*BW_W)'(bw) * (2*BW_W)'(bh);

   always_ff @(posedge clock) begin
      if (setup_load) begin
         tiles_across_ff <= W_W'(cfg_quo[0]);
         rows_used_ff    <= HGT_W'(rows_full);
         area_ff         <= AREA_W'(area_full);
      end
   end

   // Decode the incoming pixel against the current position
   assign accept      = req_tvalid && req_tready;
   assign active_now  = (W_W'(tile_index_ff) < tiles_across_ff) &&
                        (HGT_W'(row_pos_ff) < rows_used_ff) &&
                        (BW_W'(tile_col_pos_ff) < bw) &&
                        (BW_W'(tile_row_pos_ff) < bh);
   assign first_now   = (tile_col_pos_ff == '0) && (tile_row_pos_ff == '0);
   assign last_now    = (BW_W'(tile_col_pos_ff) == bw - BW_W'(1)) &&
                        (BW_W'(tile_row_pos_ff) == bh - BW_W'(1));
   assign row_end_now = (W_W'(tile_index_ff) == tiles_across_ff - W_W'(1));

   // Advance column, tile and row positions
   assign col_inc   = W_W'(column_pos_ff) + W_W'(1);
   assign tcol_inc  = BW_W'(tile_col_pos_ff) + BW_W'(1);
   assign trow_inc  = BW_W'(tile_row_pos_ff) + BW_W'(1);
   assign row_inc   = HGT_W'(row_pos_ff) + HGT_W'(1);
   assign tcol_wrap = (tcol_inc >= bw);

   always_comb begin
      column_pos_in   = col_inc[COL_W-1:0];
      tile_col_pos_in = tcol_wrap ? '0 : tcol_inc[TILE_W-1:0];
      tidx_full       = W_W'(tile_index_ff) + W_W'(tcol_wrap);
      row_pos_in      = row_pos_ff;
      tile_row_pos_in = tile_row_pos_ff;
      if (col_inc >= w) begin
         column_pos_in   = '0;
         tile_col_pos_in = '0;
         tidx_full       = '0;
         row_pos_in      = row_inc[ROW_W-1:0];
         tile_row_pos_in = (trow_inc >= bh) ? '0 : trow_inc[TILE_W-1:0];
         if (row_inc >= h) begin
            row_pos_in      = '0;
            tile_row_pos_in = '0;
         end
      end
      tile_index_in = (tidx_full >= W_W'(MAX_WIDTH)) ? '0 : tidx_full[COL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff   <= '0;
         tile_col_pos_ff <= '0;
         tile_index_ff   <= '0;
         row_pos_ff      <= '0;
         tile_row_pos_ff <= '0;
      end else if (accept) begin
         column_pos_ff   <= column_pos_in;
         tile_col_pos_ff <= tile_col_pos_in;
         tile_index_ff   <= tile_index_in;
         row_pos_ff      <= row_pos_in;
         tile_row_pos_ff <= tile_row_pos_in;
      end
   end

   // Latch the accepted word and its tile flags
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_r_ff   <= req_tdata[CHANNEL_BITS-1:0];
         pix_g_ff   <= req_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
         pix_b_ff   <= req_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
         addr_ff    <= tile_index_ff;
         first_ff   <= first_now;
         last_ff    <= last_now;
         row_end_ff <= row_end_now;
      end
   end

   // Accumulator memory: read on accept, write back in the cycle after.
   // One item is in flight at a time, so a read never overtakes a pending write.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= acc_mem[tile_index_ff];
      end
      if (mem_we) begin
         acc_mem[addr_ff] <= {sum_b, sum_g, sum_r};
      end
   end

   // Start a tile with the pixel itself, otherwise add to the stored sum
   assign sum_r = first_ff ? SUM_W'(pix_r_ff) : rd_data_ff[SUM_W-1:0] + SUM_W'(pix_r_ff);
   assign sum_g = first_ff ? SUM_W'(pix_g_ff) :
                  rd_data_ff[2*SUM_W-1:SUM_W] + SUM_W'(pix_g_ff);
   assign sum_b = first_ff ? SUM_W'(pix_b_ff) :
                  rd_data_ff[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_b_ff);

   // Tile averages: sum / area on all three channels at once
   bavg_div #(
      .LANES (3),
      .N_W   (SUM_W),
      .D_W   (AREA_W)
   ) u_pix_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_b, sum_g, sum_r}),
      .divisor  ({area_ff, area_ff, area_ff}),
      .busy     (pix_div_busy),
      .quotient (pix_quo)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bavg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cfg_start  = 1'b0;
      setup_load = 1'b0;
      mem_we     = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         bavg_pkg::ST_IDLE: begin
            if (dirty_ff) begin
               state_in = bavg_pkg::ST_SETUP;
            end else begin
               req_tready = 1'b1;
               if (req_tvalid && active_now) begin
                  state_in = bavg_pkg::ST_RMW;
               end
            end
         end
         bavg_pkg::ST_SETUP: begin
            cfg_start = 1'b1;
            state_in  = bavg_pkg::ST_SETUP_WAIT;
         end
         bavg_pkg::ST_SETUP_WAIT: begin
            if (!cfg_div_busy) begin
               setup_load = 1'b1;
               state_in   = bavg_pkg::ST_IDLE;
            end
         end
         bavg_pkg::ST_RMW: begin
            mem_we = 1'b1;
            if (last_ff) begin
               div_start = 1'b1;
               state_in  = bavg_pkg::ST_DIV;
            end else begin
               state_in = bavg_pkg::ST_IDLE;
            end
         end
         bavg_pkg::ST_DIV: begin
            if (!pix_div_busy && (!rsp_valid_ff || rsp_tready)) begin
               out_load = 1'b1;
               state_in = bavg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bavg_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: load a finished average, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_r_ff    <= pix_quo[0][CHANNEL_BITS-1:0];
         rsp_g_ff    <= pix_quo[1][CHANNEL_BITS-1:0];
         rsp_b_ff    <= pix_quo[2][CHANNEL_BITS-1:0];
         rsp_last_ff <= row_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_b_ff, rsp_g_ff, rsp_r_ff});
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_IMPL(a_accept_units_idle, req_tvalid && req_tready, !pix_div_busy && !cfg_div_busy && !dirty_ff, "pixel taken while a divider or setup is pending")
   `ASSERT_NEXT(a_tile_close_to_rmw, req_tvalid && req_tready && active_now && last_now, state_ff == bavg_pkg::ST_RMW && last_ff, "closing pixel did not reach write back")
   `ASSERT_IMPL(a_write_in_range, mem_we, W_W'(addr_ff) < tiles_across_ff, "accumulator write past the last tile column")

endmodule

`default_nettype wire
